// ----- hw/rtl/umask_pkg.sv -----
// Shared types, constants and arithmetic helpers for the 3x3 unsharp mask core.
// Used by every module under hw/rtl; depends on nothing else.
package umask_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam int NUM_CH  = 3;
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  localparam int FIFO_DEPTH = 8;

  localparam logic [13:0] DIV9_MUL   = 14'd57;
  localparam int          DIV9_SHIFT = 9;
  localparam logic [7:0]  PIX_MAX    = 8'd255;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef logic [NUM_CH-1:0][7:0] pixel_t;
  typedef pixel_t [2:0] column_t;
  typedef column_t [2:0] window_t;

  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
    logic top_en;
    logic mid_en;
    logic left_en;
    logic right_en;
  } step_t;

  typedef struct packed {
    pixel_t pix;
    logic   last;
  } result_t;

  // Exact floor(p / 9) for any 8-bit p.
  function automatic logic [4:0] div9(input logic [7:0] p);
    logic [13:0] prod;
    begin
      prod = 14'(p) * DIV9_MUL;
      return 5'(prod >> DIV9_SHIFT);
    end
  endfunction

  function automatic logic [7:0] sharpen(input logic [7:0] p, input logic [7:0] blur);
    logic [7:0] detail;
    logic [8:0] sum;
    begin
      detail = (p > blur) ? p - blur : 8'd0;
      sum    = {1'b0, p} + {1'b0, detail};
      return (sum > 9'(PIX_MAX)) ? PIX_MAX : sum[7:0];
    end
  endfunction

endpackage

// ----- hw/rtl/umask_ctrl.sv -----
// Position counters and per-transaction step decode for the unsharp mask core.
// Depends on umask_pkg.
module umask_ctrl #(
  parameter int MAX_WIDTH  = umask_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = umask_pkg::MAX_HEIGHT_DEF,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [umask_pkg::CFG_WIDTH_W-1:0]  cfg_width_i,
  input  logic [umask_pkg::CFG_HEIGHT_W-1:0] cfg_height_i,
  input  logic                               cfg_wr_i,
  input  logic                               accept_i,
  input  umask_pkg::op_e                     operation_i,
  input  umask_pkg::pixel_t                  pixel_i,
  output logic                               hold_o,
  output umask_pkg::step_t                   step_o,
  output logic [AW-1:0]                      addr_o,
  output umask_pkg::pixel_t                  pix_o
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int OW = $clog2(MAX_HEIGHT);

  logic [CW-1:0] width;
  logic [HW-1:0] height;
  logic [AW-1:0] width_m1;
  logic [OW-1:0] height_m1;
  logic [RW-1:0] height_ext;

  logic [AW-1:0] in_col_q, in_col_d;
  logic [RW-1:0] in_row_q, in_row_d;
  logic [AW-1:0] out_col_q, out_col_d;
  logic [OW-1:0] out_row_q, out_row_d;

  logic in_done;
  logic emit;
  logic last;
  logic virt;
  logic take;

  always_comb begin
    if (cfg_width_i == '0) begin
      width = CW'(1);
    end else if (32'(cfg_width_i) > 32'(MAX_WIDTH)) begin
      width = CW'(MAX_WIDTH);
    end else begin
      width = CW'(cfg_width_i);
    end
    if (cfg_height_i == '0) begin
      height = HW'(1);
    end else if (32'(cfg_height_i) > 32'(MAX_HEIGHT)) begin
      height = HW'(MAX_HEIGHT);
    end else begin
      height = HW'(cfg_height_i);
    end
  end

  assign width_m1   = AW'(width - CW'(1));
  assign height_m1  = OW'(height - HW'(1));
  assign height_ext = RW'(height);

  assign in_done = (in_row_q >= height_ext);
  assign emit    = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
  assign last    = emit && (out_col_q == width_m1) && (out_row_q == height_m1);

  // A one-row frame leaves one step that yields no output; it runs on its own
  // while the input is held off for that cycle.
  assign virt   = in_done && !emit;
  assign hold_o = virt;

  always_comb begin
    take = 1'b0;
    priority if (virt) begin
      take = 1'b1;
    end else if (accept_i) begin
      unique case (operation_i)
        umask_pkg::OP_PIXEL: take = !in_done;
        umask_pkg::OP_FLUSH: take = in_done;
      endcase
    end
  end

  always_comb begin
    step_o.valid    = take;
    step_o.emit     = emit;
    step_o.last     = last;
    step_o.top_en   = (in_row_q >= RW'(2));
    step_o.mid_en   = (in_row_q != '0);
    step_o.left_en  = (in_col_q == '0) ? (width >= CW'(2)) : (in_col_q >= AW'(2));
    step_o.right_en = (in_col_q != '0);
  end

  assign addr_o = in_col_q;
  assign pix_o  = (virt || (operation_i == umask_pkg::OP_FLUSH)) ? '0 : pixel_i;

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (take) begin
      if (in_col_q == width_m1) begin
        in_col_d = '0;
        in_row_d = in_row_q + RW'(1);
      end else begin
        in_col_d = in_col_q + AW'(1);
      end
      if (emit) begin
        if (out_col_q == width_m1) begin
          out_col_d = '0;
          out_row_d = out_row_q + OW'(1);
        end else begin
          out_col_d = out_col_q + AW'(1);
        end
      end
      if (last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end
    end
    if (cfg_wr_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

// ----- hw/rtl/umask_line_mem.sv -----
// Line memory holding the two rows above the input position, one entry per column.
// Read-modify-write with write-to-read forwarding. Depends on umask_pkg.
module umask_line_mem #(
  parameter int MAX_WIDTH = umask_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  input  umask_pkg::pixel_t pix_i,
  output umask_pkg::pixel_t rd_top_o,
  output umask_pkg::pixel_t rd_mid_o
);

  typedef struct packed {
    umask_pkg::pixel_t mid;
    umask_pkg::pixel_t top;
  } entry_t;

  entry_t            mem [MAX_WIDTH];
  entry_t            rd_q;
  entry_t            wr_data;
  logic              wr_valid_q;
  logic [AW-1:0]     wr_addr_q;
  umask_pkg::pixel_t wr_pix_q;

  // The entry shifts down one row: the new pixel becomes the middle row.
  assign wr_data.mid = wr_pix_q;
  assign wr_data.top = rd_q.mid;

  always_ff @(posedge clk_i) begin
    if (wr_valid_q) begin
      mem[wr_addr_q] <= wr_data;
    end
    if (rd_en_i) begin
      if (wr_valid_q && (wr_addr_q == rd_addr_i)) begin
        rd_q <= wr_data;
      end else begin
        rd_q <= mem[rd_addr_i];
      end
      wr_addr_q <= rd_addr_i;
      wr_pix_q  <= pix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_valid_q <= 1'b0;
    end else begin
      wr_valid_q <= rd_en_i;
    end
  end

  assign rd_top_o = rd_q.top;
  assign rd_mid_o = rd_q.mid;

endmodule

// ----- hw/rtl/umask_filter.sv -----
// Sliding 3x3 window, box blur and sharpening pipeline of the unsharp mask core.
// Depends on umask_pkg.
module umask_filter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  umask_pkg::step_t  step_i,
  input  umask_pkg::pixel_t pix_i,
  input  umask_pkg::pixel_t rd_top_i,
  input  umask_pkg::pixel_t rd_mid_i,
  output logic              res_valid_o,
  output umask_pkg::result_t res_o
);

  localparam int ROW_TOP = 0;
  localparam int ROW_MID = 1;
  localparam int ROW_BOT = 2;
  localparam int COL_LEFT   = 0;
  localparam int COL_CENTER = 1;
  localparam int COL_RIGHT  = 2;

  umask_pkg::step_t   s1_step_q;
  umask_pkg::pixel_t  s1_pix_q;
  umask_pkg::column_t col1_q;
  umask_pkg::column_t col2_q;
  umask_pkg::column_t new_col;
  umask_pkg::window_t nb_d;

  logic               s2_valid_q;
  logic               s2_last_q;
  umask_pkg::window_t nb_q;
  logic [umask_pkg::NUM_CH-1:0][7:0] blur_d;

  logic               s3_valid_q;
  logic               s3_last_q;
  logic [umask_pkg::NUM_CH-1:0][7:0] blur_q;
  umask_pkg::pixel_t  center_q;

  always_comb begin
    new_col[ROW_TOP] = s1_step_q.top_en ? rd_top_i : '0;
    new_col[ROW_MID] = s1_step_q.mid_en ? rd_mid_i : '0;
    new_col[ROW_BOT] = s1_pix_q;
    nb_d[COL_LEFT]   = s1_step_q.left_en ? col1_q : '0;
    nb_d[COL_CENTER] = col2_q;
    nb_d[COL_RIGHT]  = s1_step_q.right_en ? new_col : '0;
  end

  always_comb begin
    for (int ch = 0; ch < umask_pkg::NUM_CH; ch++) begin
      blur_d[ch] = '0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          blur_d[ch] = blur_d[ch] + 8'(umask_pkg::div9(nb_q[c][r][ch]));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.valid) begin
      s1_pix_q <= pix_i;
    end
    if (s1_step_q.valid) begin
      col1_q <= col2_q;
      col2_q <= new_col;
      nb_q      <= nb_d;
      s2_last_q <= s1_step_q.last;
    end
    if (s2_valid_q) begin
      blur_q    <= blur_d;
      center_q  <= nb_q[COL_CENTER][ROW_MID];
      s3_last_q <= s2_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_step_q  <= '0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_step_q  <= step_i;
      s2_valid_q <= s1_step_q.valid && s1_step_q.emit;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_comb begin
    for (int ch = 0; ch < umask_pkg::NUM_CH; ch++) begin
      res_o.pix[ch] = umask_pkg::sharpen(center_q[ch], blur_q[ch]);
    end
    res_o.last = s3_last_q;
  end

  assign res_valid_o = s3_valid_q;

endmodule

// ----- hw/rtl/umask_out_fifo.sv -----
// Output buffer with credit tracking for the unsharp mask core.
// Depends on umask_pkg.
module umask_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               reserve_i,
  input  logic               push_i,
  input  umask_pkg::result_t push_data_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output umask_pkg::result_t out_data_o,
  output logic               full_o
);

  localparam int PW    = $clog2(umask_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(umask_pkg::FIFO_DEPTH + 1);

  umask_pkg::result_t fifo_mem [umask_pkg::FIFO_DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] credit_q, credit_d;
  logic             pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = fifo_mem[rd_ptr_q];
  assign full_o      = (credit_q >= CNT_W'(umask_pkg::FIFO_DEPTH));

  assign cnt_d    = cnt_q + CNT_W'(push_i) - CNT_W'(pop);
  assign credit_d = credit_q + CNT_W'(reserve_i) - CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_mem[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      credit_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      cnt_q    <= cnt_d;
      credit_q <= credit_d;
    end
  end

endmodule

// ----- hw/rtl/unsharp_mask_3x3_rgb_core.sv -----
// Top level of the 3x3 box-blur unsharp mask core for raster-order RGB streams.
// Instantiates umask_ctrl, umask_line_mem, umask_filter and umask_out_fifo; uses umask_pkg.
//
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one transaction per pixel, or a
//   flush transaction (operation_i = 1) that drains one pending result once the whole
//   frame has been taken in. The output channel (out_valid_o / out_stall_i) carries one
//   sharpened pixel per transaction, with last_of_frame_o on the final pixel of a frame.
//   Frame size is set over the APB port (frame_width at 0x0, frame_height at 0x4);
//   a write restarts the frame position and must only happen while the core is idle.
// Throughput and latency:
//   One input transaction per clock while in_stall_o is low, limited by the single
//   read and single write of the line memory per cycle. A result passes the filter
//   registers s1, s2, s3 and the output buffer; the stream lag is frame_width + 1
//   transactions. After the last pixel of a one-row frame the input stalls for one cycle.
// Reset:
//   Position counters clear, frame size returns to 1 x 1; the line memory needs no
//   clearing pass. The core accepts transactions in the first cycle after reset.
// Receiver stall:
//   Up to eight results are buffered; beyond that in_stall_o rises until space frees.
module unsharp_mask_3x3_rgb_core #(
  parameter int MAX_WIDTH  = umask_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = umask_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [umask_pkg::PADDR_W-1:0] paddr,
  input  logic [umask_pkg::PDATA_W-1:0] pwdata,
  output logic [umask_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [7:0]                    in_red_i,
  input  logic [7:0]                    in_green_i,
  input  logic [7:0]                    in_blue_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_red_o,
  output logic [7:0]                    out_green_o,
  output logic [7:0]                    out_blue_o,
  output logic                          last_of_frame_o
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [umask_pkg::CFG_WIDTH_W-1:0]  frame_width_q;
  logic [umask_pkg::CFG_HEIGHT_W-1:0] frame_height_q;
  logic                               cfg_wr;
  umask_pkg::reg_idx_e                reg_idx;

  logic               in_accept;
  logic               hold;
  logic               full;
  umask_pkg::pixel_t  in_pix;
  umask_pkg::step_t   step;
  logic [AW-1:0]      step_addr;
  umask_pkg::pixel_t  step_pix;
  umask_pkg::pixel_t  rd_top;
  umask_pkg::pixel_t  rd_mid;
  logic               res_valid;
  umask_pkg::result_t res;
  umask_pkg::result_t out_data;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = umask_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    unique case (reg_idx)
      umask_pkg::REG_FRAME_WIDTH:  prdata = umask_pkg::PDATA_W'(frame_width_q);
      umask_pkg::REG_FRAME_HEIGHT: prdata = umask_pkg::PDATA_W'(frame_height_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= umask_pkg::CFG_WIDTH_W'(1);
      frame_height_q <= umask_pkg::CFG_HEIGHT_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        umask_pkg::REG_FRAME_WIDTH:
          frame_width_q <= pwdata[umask_pkg::CFG_WIDTH_W-1:0];
        umask_pkg::REG_FRAME_HEIGHT:
          frame_height_q <= pwdata[umask_pkg::CFG_HEIGHT_W-1:0];
      endcase
    end
  end

  assign in_stall_o = hold || full;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_pix[umask_pkg::CH_RED]   = in_red_i;
    in_pix[umask_pkg::CH_GREEN] = in_green_i;
    in_pix[umask_pkg::CH_BLUE]  = in_blue_i;
  end

  umask_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_width_i  (frame_width_q),
    .cfg_height_i (frame_height_q),
    .cfg_wr_i     (cfg_wr),
    .accept_i     (in_accept),
    .operation_i  (umask_pkg::op_e'(operation_i)),
    .pixel_i      (in_pix),
    .hold_o       (hold),
    .step_o       (step),
    .addr_o       (step_addr),
    .pix_o        (step_pix)
  );

  umask_line_mem #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (step.valid),
    .rd_addr_i (step_addr),
    .pix_i     (step_pix),
    .rd_top_o  (rd_top),
    .rd_mid_o  (rd_mid)
  );

  umask_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .pix_i       (step_pix),
    .rd_top_i    (rd_top),
    .rd_mid_i    (rd_mid),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  umask_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .reserve_i   (step.valid && step.emit),
    .push_i      (res_valid),
    .push_data_i (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data),
    .full_o      (full)
  );

  assign out_red_o       = out_data.pix[umask_pkg::CH_RED];
  assign out_green_o     = out_data.pix[umask_pkg::CH_GREEN];
  assign out_blue_o      = out_data.pix[umask_pkg::CH_BLUE];
  assign last_of_frame_o = out_data.last;

endmodule
